### rtl/core/spq_pkg.sv
// Package for the sorted priority queue: sizes, status and action codes,
// and the entry and cell control types shared by the cell row and the top level.
// No dependencies.
`default_nettype none

package spq_pkg;

    // Sizes of the queue and of one entry.
    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_BITS  = 16;
    localparam int PRIORITY_BITS = 4;
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // Action codes of an input item.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One queue entry.
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0]  payload;
        logic [PRIORITY_BITS-1:0] priority_val;
    } t_entry;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/core/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_occupied,
    input  wire logic      i_left_behind,
    input  wire t_entry    i_left,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_behind
);

    t_entry r_entry;
    t_entry n_entry;

    // The new entry goes behind this one when this one has equal or higher priority.
    assign o_behind = i_occupied && (r_entry.priority_val >= i_ctl.new_entry.priority_val);
    assign o_entry  = r_entry;

    // Keep, take the new entry, take the left neighbor on insert, or the right on remove.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_behind) begin
            if (i_left_behind) begin
                n_entry = i_ctl.new_entry;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

### rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of shifting cells, the entry
// count and the result register. Depends on spq_pkg and spq_cell.
`default_nettype none

// The queue takes one insert or remove per cycle and delivers its result in the
// cycle after the transfer; the whole row of cells shifts in the transfer cycle,
// each cell comparing its own priority with the incoming one, so the rate is
// set only by the result register draining (input ready follows it). Entries of
// equal priority leave in arrival order. An insert into a full queue is dropped
// with status full, a remove from an empty queue gives status empty, and the
// payload and priority of every result that is not a successful remove are zero.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_action,
    input  wire logic [PAYLOAD_BITS-1:0]  i_payload,
    input  wire logic [PRIORITY_BITS-1:0] i_priority_req,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [1:0]                    o_status,
    output logic [PAYLOAD_BITS-1:0]       o_out_payload,
    output logic [PRIORITY_BITS-1:0]      o_out_priority,
    output logic [CNT_BITS-1:0]           o_occupancy
);

    logic [CNT_BITS-1:0]      r_count;
    logic [CNT_BITS-1:0]      n_count;
    logic                     r_out_valid;
    logic [1:0]               r_status;
    logic [1:0]               n_status;
    logic [PAYLOAD_BITS-1:0]  r_pay;
    logic [PAYLOAD_BITS-1:0]  n_pay;
    logic [PRIORITY_BITS-1:0] r_pri;
    logic [PRIORITY_BITS-1:0] n_pri;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;
    t_entry    w_entry  [QUEUE_DEPTH];
    logic      w_behind [QUEUE_DEPTH];

    // The input is ready whenever the result register is free or draining.
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);

    // Operation broadcast to the cell row.
    assign w_ctl.ins                    = w_accept && (i_action == ACT_INSERT) && !w_full;
    assign w_ctl.rem                    = w_accept && (i_action == ACT_REMOVE) && !w_empty;
    assign w_ctl.new_entry.payload      = i_payload;
    assign w_ctl.new_entry.priority_val = i_priority_req;

    // Row of cells; slot zero is the front of the queue.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   w_occ;
        logic   w_lb;
        t_entry w_left;
        t_entry w_right;

        assign w_occ = (CNT_BITS'(i) < r_count);

        if (i == 0) begin : g_head
            assign w_lb   = 1'b1;
            assign w_left = '0;
        end else begin : g_mid
            assign w_lb   = w_behind[i-1];
            assign w_left = w_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[i+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (w_occ),
            .i_left_behind (w_lb),
            .i_left        (w_left),
            .i_right       (w_right),
            .o_entry       (w_entry[i]),
            .o_behind      (w_behind[i])
        );
    end

    // Result of the item being transferred in and the next entry count.
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_pay    = '0;
        n_pri    = '0;
        if (i_action == ACT_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_BITS'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_BITS'(1);
                n_pay   = w_entry[0].payload;
                n_pri   = w_entry[0].priority_val;
            end
        end
    end

    // Control state: entry count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result status, payload and priority register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_pay    <= n_pay;
            r_pri    <= n_pri;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_payload  = r_pay;
    assign o_out_priority = r_pri;
    assign o_occupancy    = r_count;

    // The entry count never goes past the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // A successful insert grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + CNT_BITS'(1)))
        else $error("insert did not grow the entry count");

    // A dropped insert is reported only with a full queue.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_count == CNT_BITS'(QUEUE_DEPTH)))
        else $error("full status with room left");

    // An empty remove is reported only with an empty queue.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries held");

    // The two front entries stay in priority order.
    a_front_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_BITS'(2)) |->
            (w_entry[0].priority_val >= w_entry[1].priority_val))
        else $error("front entries out of order");

endmodule

`default_nettype wire
